/* rtl/segment_intersect_2d_assert.svh */
//------------------------------------------------------------------------------
// Assertion macros for segment_intersect_2d
// Shorthand for clocked, reset-qualified concurrent assertions.
//------------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECT_2D_ASSERT_SVH
`define SEGMENT_INTERSECT_2D_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SI2D_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment_intersect_2d assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SI2D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment_intersect_2d assertion failed");

`endif

/* rtl/si2d_pkg.sv */
//------------------------------------------------------------------------------
// si2d_pkg
// Types and constants shared by the 2D segment intersection block.
//------------------------------------------------------------------------------
package si2d_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_B  = 16;
  localparam int EPS_W   = 32;

  localparam logic [EPS_W-1:0] EPS_RESET = 32'd42950;

  // Result status codes.
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_INSIDE  = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_dir_x;
    coord_t a_dir_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_dir_x;
    coord_t b_dir_y;
  } si2d_in_t;

  typedef struct packed {
    logic [1:0] status;
    coord_t     param_a;
    coord_t     param_b;
    coord_t     cross_x;
    coord_t     cross_y;
  } si2d_out_t;

endpackage

/* rtl/segment_intersect_2d.sv */
//------------------------------------------------------------------------------
// segment_intersect_2d
// Intersection of two parametric 2D segments in signed Q16.16.
//------------------------------------------------------------------------------
// The block takes one segment pair per cycle while in_stall is low and returns
// one result per pair, in order. The pipeline is made of the two restoring
// dividers, which produce one quotient bit per pipeline stage (32 stages), plus
// five front stages that form the differences, products, determinant, magnitudes
// and overflow tests, and three back stages that saturate the parameters,
// multiply for the point and add.
// All stages move together: when a result waits at the output and out_stall is
// high, the whole pipeline holds and in_stall is raised; otherwise a transfer
// is taken in every cycle. The det_epsilon register is written through cfg_we
// and cfg_wdata and must only change while no pair is in flight.
//------------------------------------------------------------------------------
module segment_intersect_2d (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [si2d_pkg::EPS_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  si2d_pkg::si2d_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output si2d_pkg::si2d_out_t            out_data
);
  import si2d_pkg::*;

  // Internal widths, all following from the coordinate format.
  localparam int DIF_W = COORD_W + 1;       // start point differences
  localparam int PD_W  = 2 * COORD_W;       // direction by direction product
  localparam int PN_W  = 2 * COORD_W + 1;   // direction by difference product
  localparam int DET_W = 2 * COORD_W + 1;   // determinant
  localparam int NUM_W = 2 * COORD_W + 2;   // numerators
  localparam int REM_W = 2 * COORD_W + 2;   // divider remainder
  localparam int PT_W  = 2 * COORD_W + 2;   // point sum
  localparam int SH_W  = COORD_W - FRAC_B;  // numerator shift for the top part

  localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] ONE_Q = COORD_W'(1) << FRAC_B;

  // Divider stage payload: both quotients advance one bit per stage.
  typedef struct packed {
    logic [REM_W-1:0]   rem1;
    logic [REM_W-1:0]   rem2;
    logic [COORD_W-1:0] nl1;
    logic [COORD_W-1:0] nl2;
    logic [COORD_W-1:0] q1;
    logic [COORD_W-1:0] q2;
    logic [DET_W-1:0]   d;
    logic               neg1;
    logic               neg2;
    logic               ovf1;
    logic               ovf2;
    logic               par;
    coord_t             ax;
    coord_t             ay;
    coord_t             adx;
    coord_t             ady;
  } div_t;

  function automatic div_t div_step(div_t x);
    logic [REM_W-1:0] r1;
    logic [REM_W-1:0] r2;
    div_t             y;
    y  = x;
    r1 = {x.rem1[REM_W-2:0], x.nl1[COORD_W-1]};
    r2 = {x.rem2[REM_W-2:0], x.nl2[COORD_W-1]};
    if (r1 >= REM_W'(x.d)) begin
      y.rem1 = r1 - REM_W'(x.d);
      y.q1   = {x.q1[COORD_W-2:0], 1'b1};
    end else begin
      y.rem1 = r1;
      y.q1   = {x.q1[COORD_W-2:0], 1'b0};
    end
    if (r2 >= REM_W'(x.d)) begin
      y.rem2 = r2 - REM_W'(x.d);
      y.q2   = {x.q2[COORD_W-2:0], 1'b1};
    end else begin
      y.rem2 = r2;
      y.q2   = {x.q2[COORD_W-2:0], 1'b0};
    end
    y.nl1 = {x.nl1[COORD_W-2:0], 1'b0};
    y.nl2 = {x.nl2[COORD_W-2:0], 1'b0};
    return y;
  endfunction

  // Applies the sign to a quotient magnitude and clamps it to the coordinate range.
  function automatic coord_t sat_q(logic [COORD_W-1:0] q, logic neg, logic ovf);
    coord_t r;
    if (ovf) begin
      r = neg ? C_MIN : C_MAX;
    end else if (!neg) begin
      r = q[COORD_W-1] ? C_MAX : coord_t'(q);
    end else if (q > C_MIN) begin
      r = C_MIN;
    end else begin
      r = coord_t'(-q);
    end
    return r;
  endfunction

  function automatic logic in_unit(coord_t t);
    return !t[COORD_W-1] && (t <= ONE_Q);
  endfunction

  function automatic coord_t sat_pt(logic signed [PT_W-1:0] v);
    coord_t r;
    if ((v[PT_W-1:COORD_W-1] == '0) || (v[PT_W-1:COORD_W-1] == '1)) begin
      r = v[COORD_W-1:0];
    end else begin
      r = v[PT_W-1] ? C_MIN : C_MAX;
    end
    return r;
  endfunction

  // Configuration register.
  logic [EPS_W-1:0] eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_we) begin
      eps_r <= cfg_wdata;
    end
  end

  // The pipeline advances as a whole unless a result waits and is stalled.
  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Stage 1: start point differences.
  logic                     s1_v_r;
  coord_t                   s1_ax_r, s1_ay_r, s1_adx_r, s1_ady_r, s1_bdx_r, s1_bdy_r;
  logic signed [DIF_W-1:0]  s1_dx_r, s1_dy_r;

  // Stage 2: the six products.
  logic                     s2_v_r;
  coord_t                   s2_ax_r, s2_ay_r, s2_adx_r, s2_ady_r;
  logic signed [PD_W-1:0]   s2_pa_r, s2_pb_r;
  logic signed [PN_W-1:0]   s2_p1a_r, s2_p1b_r, s2_p2a_r, s2_p2b_r;

  // Stage 3: determinant and numerators.
  logic                     s3_v_r;
  coord_t                   s3_ax_r, s3_ay_r, s3_adx_r, s3_ady_r;
  logic signed [DET_W-1:0]  s3_det_r;
  logic signed [NUM_W-1:0]  s3_n1_r, s3_n2_r;

  // Stage 4: magnitudes, quotient signs and the parallel test.
  logic                     s4_v_r;
  coord_t                   s4_ax_r, s4_ay_r, s4_adx_r, s4_ady_r;
  logic [DET_W-1:0]         s4_ad_r;
  logic [NUM_W-1:0]         s4_an1_r, s4_an2_r;
  logic                     s4_neg1_r, s4_neg2_r, s4_par_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax_r  <= in_data.a_start_x;
      s1_ay_r  <= in_data.a_start_y;
      s1_adx_r <= in_data.a_dir_x;
      s1_ady_r <= in_data.a_dir_y;
      s1_bdx_r <= in_data.b_dir_x;
      s1_bdy_r <= in_data.b_dir_y;
      s1_dx_r  <= DIF_W'(in_data.a_start_x) - DIF_W'(in_data.b_start_x);
      s1_dy_r  <= DIF_W'(in_data.a_start_y) - DIF_W'(in_data.b_start_y);

      s2_ax_r  <= s1_ax_r;
      s2_ay_r  <= s1_ay_r;
      s2_adx_r <= s1_adx_r;
      s2_ady_r <= s1_ady_r;
      s2_pa_r  <= PD_W'(s1_adx_r) * PD_W'(s1_bdy_r);
      s2_pb_r  <= PD_W'(s1_ady_r) * PD_W'(s1_bdx_r);
      s2_p1a_r <= PN_W'(s1_bdx_r) * PN_W'(s1_dy_r);
      s2_p1b_r <= PN_W'(s1_bdy_r) * PN_W'(s1_dx_r);
      s2_p2a_r <= PN_W'(s1_adx_r) * PN_W'(s1_dy_r);
      s2_p2b_r <= PN_W'(s1_ady_r) * PN_W'(s1_dx_r);

      s3_ax_r  <= s2_ax_r;
      s3_ay_r  <= s2_ay_r;
      s3_adx_r <= s2_adx_r;
      s3_ady_r <= s2_ady_r;
      s3_det_r <= DET_W'(s2_pa_r) - DET_W'(s2_pb_r);
      s3_n1_r  <= NUM_W'(s2_p1a_r) - NUM_W'(s2_p1b_r);
      s3_n2_r  <= NUM_W'(s2_p2a_r) - NUM_W'(s2_p2b_r);

      s4_ax_r   <= s3_ax_r;
      s4_ay_r   <= s3_ay_r;
      s4_adx_r  <= s3_adx_r;
      s4_ady_r  <= s3_ady_r;
      s4_ad_r   <= s3_det_r[DET_W-1] ? DET_W'(-s3_det_r) : DET_W'(s3_det_r);
      s4_an1_r  <= s3_n1_r[NUM_W-1] ? NUM_W'(-s3_n1_r) : NUM_W'(s3_n1_r);
      s4_an2_r  <= s3_n2_r[NUM_W-1] ? NUM_W'(-s3_n2_r) : NUM_W'(s3_n2_r);
      s4_neg1_r <= s3_n1_r[NUM_W-1] ^ s3_det_r[DET_W-1];
      s4_neg2_r <= s3_n2_r[NUM_W-1] ^ s3_det_r[DET_W-1];
      s4_par_r  <= (s3_det_r[DET_W-1] ? DET_W'(-s3_det_r) : DET_W'(s3_det_r))
                   <= DET_W'(eps_r);
    end
  end

  // Stage 5 (divider entry) and the quotient stages, one bit each.
  div_t dv_r     [0:COORD_W];
  logic dv_v_r   [0:COORD_W];
  div_t dv0_nxt;

  // A quotient of 2^COORD_W or more is flagged here; otherwise the top part
  // of the shifted numerator is already below the divisor.
  always_comb begin
    dv0_nxt      = '0;
    dv0_nxt.d    = s4_ad_r;
    dv0_nxt.rem1 = REM_W'(s4_an1_r >> SH_W);
    dv0_nxt.rem2 = REM_W'(s4_an2_r >> SH_W);
    dv0_nxt.nl1  = {s4_an1_r[SH_W-1:0], {FRAC_B{1'b0}}};
    dv0_nxt.nl2  = {s4_an2_r[SH_W-1:0], {FRAC_B{1'b0}}};
    dv0_nxt.ovf1 = REM_W'(s4_an1_r >> SH_W) >= REM_W'(s4_ad_r);
    dv0_nxt.ovf2 = REM_W'(s4_an2_r >> SH_W) >= REM_W'(s4_ad_r);
    dv0_nxt.neg1 = s4_neg1_r;
    dv0_nxt.neg2 = s4_neg2_r;
    dv0_nxt.par  = s4_par_r;
    dv0_nxt.ax   = s4_ax_r;
    dv0_nxt.ay   = s4_ay_r;
    dv0_nxt.adx  = s4_adx_r;
    dv0_nxt.ady  = s4_ady_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  for (genvar k = 0; k < COORD_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k+1] <= div_step(dv_r[k]);
      end
    end
  end

  // Back stage 1: signed, saturated parameters and the status.
  logic       b1_v_r;
  coord_t     b1_t1_r, b1_t2_r, b1_ax_r, b1_ay_r, b1_adx_r, b1_ady_r;
  logic [1:0] b1_st_r;
  coord_t     b1_t1_nxt, b1_t2_nxt;
  logic [1:0] b1_st_nxt;
  div_t       dl;

  assign dl = dv_r[COORD_W];

  always_comb begin
    b1_t1_nxt = sat_q(dl.q1, dl.neg1, dl.ovf1);
    b1_t2_nxt = sat_q(dl.q2, dl.neg2, dl.ovf2);
    if (dl.par) begin
      b1_st_nxt = ST_NONE;
      b1_t1_nxt = '0;
      b1_t2_nxt = '0;
    end else if (in_unit(b1_t1_nxt) && in_unit(b1_t2_nxt)) begin
      b1_st_nxt = ST_INSIDE;
    end else begin
      b1_st_nxt = ST_OUTSIDE;
    end
  end

  // Back stage 2: direction by parameter products for the point.
  logic                   b2_v_r;
  coord_t                 b2_t1_r, b2_t2_r, b2_ax_r, b2_ay_r;
  logic [1:0]             b2_st_r;
  logic signed [PD_W-1:0] b2_mx_r, b2_my_r;

  // Back stage 3: the output register.
  si2d_out_t              out_data_r;
  logic signed [PT_W-1:0] sum_x, sum_y;

  assign sum_x = ((PT_W'(b2_ax_r) <<< FRAC_B) + PT_W'(b2_mx_r)) >>> FRAC_B;
  assign sum_y = ((PT_W'(b2_ay_r) <<< FRAC_B) + PT_W'(b2_my_r)) >>> FRAC_B;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r      <= 1'b0;
      b2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b1_v_r      <= dv_v_r[COORD_W];
      b2_v_r      <= b1_v_r;
      out_valid_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_t1_r  <= b1_t1_nxt;
      b1_t2_r  <= b1_t2_nxt;
      b1_st_r  <= b1_st_nxt;
      b1_ax_r  <= dl.ax;
      b1_ay_r  <= dl.ay;
      b1_adx_r <= dl.adx;
      b1_ady_r <= dl.ady;

      b2_t1_r <= b1_t1_r;
      b2_t2_r <= b1_t2_r;
      b2_st_r <= b1_st_r;
      b2_ax_r <= b1_ax_r;
      b2_ay_r <= b1_ay_r;
      b2_mx_r <= PD_W'(b1_adx_r) * PD_W'(b1_t1_r);
      b2_my_r <= PD_W'(b1_ady_r) * PD_W'(b1_t1_r);

      // A parallel pair reports zero everywhere.
      out_data_r.status <= b2_st_r;
      if (b2_st_r == ST_NONE) begin
        out_data_r.param_a <= '0;
        out_data_r.param_b <= '0;
        out_data_r.cross_x <= '0;
        out_data_r.cross_y <= '0;
      end else begin
        out_data_r.param_a <= b2_t1_r;
        out_data_r.param_b <= b2_t2_r;
        out_data_r.cross_x <= sat_pt(sum_x);
        out_data_r.cross_y <= sat_pt(sum_y);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the pipeline control and the result encoding.
`include "segment_intersect_2d_assert.svh"
  `SI2D_ASSERT(a_stall_only_when_blocked, in_stall, out_valid && out_stall)
  `SI2D_ASSERT_NEXT(a_front_takes_transfer, in_valid && !in_stall, s1_v_r)
  `SI2D_ASSERT(a_parallel_zero, out_valid && (out_data.status == ST_NONE), (out_data.param_a == '0) && (out_data.param_b == '0) && (out_data.cross_x == '0) && (out_data.cross_y == '0))
  `SI2D_ASSERT(a_inside_nonneg, out_valid && (out_data.status == ST_INSIDE), !out_data.param_a[COORD_W-1] && !out_data.param_b[COORD_W-1])

endmodule
